### rtl/nsr_pkg.sv
// Shared widths and defaults for the Newton square root block.
`default_nettype none

package nsr_pkg;

	localparam int RAD_W            = 32; // radicand field
	localparam int ROOT_W           = 25; // root field
	localparam int GUESS_W          = 32; // running guess, always below 2^32
	localparam int ISQ_W            = 16; // integer root of a 32-bit word
	localparam int NEWTON_STEPS_DEF = 10;
	localparam int FRAC_BITS_DEF    = 16;

endpackage

`default_nettype wire

### rtl/nsr_if.sv
// Valid/ready stream interfaces for the radicand and root channels.
`default_nettype none

interface nsr_rad_if;
	import nsr_pkg::*;

	logic             valid;
	logic             ready;
	logic [RAD_W-1:0] radicand;

	modport source (output valid, output radicand, input ready);
	modport sink   (input valid, input radicand, output ready);
endinterface

interface nsr_root_if;
	import nsr_pkg::*;

	logic              valid;
	logic              ready;
	logic [ROOT_W-1:0] root;

	modport source (output valid, output root, input ready);
	modport sink   (input valid, input root, output ready);
endinterface

`default_nettype wire

### rtl/newton_square_root_top.sv
// Newton square root top level: sequencer, guess register and output register.
//
// Usage:
//   din carries one unsigned Q16.16 radicand per transfer; dout returns one
//   Q9.16 root per radicand, in order. Both are valid/ready channels.
//   The block works on one radicand at a time: din.ready is high only while
//   the sequencer is idle.
//   A zero radicand goes from idle straight to the done state and on into the
//   output register. Any other radicand passes through the bit-serial integer
//   root, then one pass of the radix-2 divider per Newton step, then into the
//   output register. A new radicand is taken only once the sequencer has
//   handed the last root to the output register and gone back to idle.
//   A finished root waits in the output register; the next radicand is taken
//   while it waits. If a second root completes before the first is taken, the
//   sequencer holds it until the receiver is ready.
//   Reset (arst_n low) empties the output register and idles the sequencer.
`default_nettype none

module newton_square_root_top #(
	parameter int NEWTON_STEPS = nsr_pkg::NEWTON_STEPS_DEF,
	parameter int FRAC_BITS    = nsr_pkg::FRAC_BITS_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	nsr_rad_if.sink    din,
	nsr_root_if.source dout
);
	import nsr_pkg::*;

	localparam int NUM_W  = RAD_W + FRAC_BITS;
	localparam int STEP_W = $clog2(NEWTON_STEPS + 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_ROOT = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0]        state_q;
	logic [STEP_W-1:0] step_q;
	logic              isq_go_q;
	logic              div_go_q;
	logic              out_full_q;
	logic [RAD_W-1:0]  x_q;
	logic [GUESS_W-1:0] g_q;
	logic [ROOT_W-1:0] root_q;

	logic              isq_done;
	logic [ISQ_W-1:0]  isq_root;
	logic              div_done;
	logic [NUM_W-1:0]  div_quo;

	logic [ISQ_W-1:0]   root_nz;
	logic [GUESS_W-1:0] g_init;
	logic [GUESS_W:0]   g_sum;
	logic               in_xfer;
	logic               out_load;

	nsr_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (isq_go_q),
		.n      (x_q >> FRAC_BITS),
		.done   (isq_done),
		.root   (isq_root)
	);

	nsr_div #(
		.NUM_W (NUM_W),
		.DEN_W (GUESS_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_go_q),
		.num    ({x_q, {FRAC_BITS{1'b0}}}),
		.den    (g_q),
		.done   (div_done),
		.quo    (div_quo)
	);

	// radicand below one starts from a guess of one
	assign root_nz  = (isq_root == '0) ? ISQ_W'(1) : isq_root;
	assign g_init   = {{(GUESS_W - ISQ_W){1'b0}}, root_nz} << FRAC_BITS;
	assign g_sum    = {1'b0, g_q} + {1'b0, div_quo[GUESS_W-1:0]};
	assign in_xfer  = din.valid && din.ready;
	assign out_load = (state_q == ST_DONE) && (!out_full_q || dout.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			step_q     <= '0;
			isq_go_q   <= 1'b0;
			div_go_q   <= 1'b0;
			out_full_q <= 1'b0;
		end else begin
			isq_go_q <= 1'b0;
			div_go_q <= 1'b0;

			if (out_load) begin
				out_full_q <= 1'b1;
			end else if (dout.ready) begin
				out_full_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						if (din.radicand == '0) begin
							state_q <= ST_DONE;
						end else begin
							isq_go_q <= 1'b1;
							state_q  <= ST_ROOT;
						end
					end
				end
				ST_ROOT: begin
					if (isq_done) begin
						step_q   <= '0;
						div_go_q <= 1'b1;
						state_q  <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						if (step_q == STEP_W'(NEWTON_STEPS - 1)) begin
							state_q <= ST_DONE;
						end else begin
							step_q   <= step_q + 1'b1;
							div_go_q <= 1'b1;
						end
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			x_q <= din.radicand;
			g_q <= '0;
		end else if (state_q == ST_ROOT && isq_done) begin
			g_q <= g_init;
		end else if (state_q == ST_DIV && div_done) begin
			g_q <= g_sum[GUESS_W:1];
		end
		if (out_load) begin
			root_q <= g_q[ROOT_W-1:0];
		end
	end

	assign din.ready  = (state_q == ST_IDLE);
	assign dout.valid = out_full_q;
	assign dout.root  = root_q;

endmodule

`default_nettype wire

### rtl/nsr_isqrt.sv
// Bit-serial integer square root, two radicand bits per cycle.
`default_nettype none

module nsr_isqrt (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [nsr_pkg::RAD_W-1:0]  n,
	output logic                            done,
	output logic [nsr_pkg::ISQ_W-1:0]       root
);
	import nsr_pkg::*;

	localparam int CNT_W = $clog2(ISQ_W);
	localparam int REM_W = ISQ_W + 1;
	localparam int SH_W  = REM_W + 2;

	logic [RAD_W-1:0] n_q;
	logic [REM_W-1:0] rem_q;
	logic [ISQ_W-1:0] root_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [SH_W-1:0]  rem_sh;
	logic [SH_W-1:0]  trial;
	logic             take;

	assign rem_sh = {rem_q, n_q[RAD_W-1 -: 2]};
	assign trial  = {1'b0, root_q, 2'b01};
	assign take   = (rem_sh >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(ISQ_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			n_q    <= n;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			n_q <= {n_q[RAD_W-3:0], 2'b00};
			if (take) begin
				rem_q  <= REM_W'(rem_sh - trial);
				root_q <= {root_q[ISQ_W-2:0], 1'b1};
			end else begin
				rem_q  <= rem_sh[REM_W-1:0];
				root_q <= {root_q[ISQ_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

`default_nettype wire

### rtl/nsr_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
`default_nettype none

module nsr_div #(
	parameter int NUM_W = nsr_pkg::RAD_W + nsr_pkg::FRAC_BITS_DEF,
	parameter int DEN_W = nsr_pkg::GUESS_W
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [NUM_W-1:0] num,
	input  wire logic [DEN_W-1:0] den,
	output logic                  done,
	output logic [NUM_W-1:0]      quo
);
	import nsr_pkg::*;

	localparam int CNT_W = $clog2(NUM_W);

	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;
	logic [NUM_W-1:0] nq_q;   // dividend bits shift out at the top, quotient bits in
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [DEN_W:0]   trial;
	logic             take;

	assign trial = {rem_q, nq_q[NUM_W-1]};
	assign take  = (trial >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			den_q <= den;
			rem_q <= '0;
			nq_q  <= num;
		end else if (busy_q) begin
			if (take) begin
				rem_q <= DEN_W'(trial - {1'b0, den_q});
			end else begin
				rem_q <= trial[DEN_W-1:0];
			end
			nq_q <= {nq_q[NUM_W-2:0], take};
		end
	end

	assign done = done_q;
	assign quo  = nq_q;

endmodule

`default_nettype wire

### test/newton_square_root_top_tb.sv
// Testbench for the Newton square root block: directed table, random radicands, stalls.
`timescale 1ns / 1ps

module newton_square_root_top_tb;
	import nsr_pkg::*;

	localparam int NEWTON_STEPS = NEWTON_STEPS_DEF;
	localparam int FRAC_BITS    = FRAC_BITS_DEF;
	localparam int LATENCY      = 18 + NEWTON_STEPS * (32 + FRAC_BITS + 2);
	localparam int RANDOM_ITEMS = 500;
	localparam int LONG_HOLD    = 4000;

	typedef struct packed {
		logic [RAD_W-1:0]  radicand;
		logic              typed;
		logic [ROOT_W-1:0] root;
	} stim_row_t;

	// typed roots are exact squares and zero; the rest go through newton_root
	localparam int N_DIR = 16;
	localparam stim_row_t DIR_ROWS [N_DIR] = '{
		'{32'h0000_0000, 1'b1, 25'h000_0000},
		'{32'h0001_0000, 1'b1, 25'h001_0000},
		'{32'h0004_0000, 1'b1, 25'h002_0000},
		'{32'h0009_0000, 1'b1, 25'h003_0000},
		'{32'h0100_0000, 1'b1, 25'h010_0000},
		'{32'h4000_0000, 1'b1, 25'h080_0000},
		'{32'h0000_0001, 1'b0, 25'h0},
		'{32'h0000_FFFF, 1'b0, 25'h0},
		'{32'h0000_8000, 1'b0, 25'h0},
		'{32'h0001_0001, 1'b0, 25'h0},
		'{32'hFFFF_FFFF, 1'b0, 25'h0},
		'{32'hFFFF_0000, 1'b0, 25'h0},
		'{32'h8000_0000, 1'b0, 25'h0},
		'{32'h7FFF_FFFF, 1'b0, 25'h0},
		'{32'hAAAA_AAAA, 1'b0, 25'h0},
		'{32'h5555_5555, 1'b0, 25'h0}
	};

	logic clk;
	logic arst_n;

	nsr_rad_if  din ();
	nsr_root_if dout ();

	newton_square_root_top #(
		.NEWTON_STEPS(NEWTON_STEPS),
		.FRAC_BITS   (FRAC_BITS)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.din   (din.sink),
		.dout  (dout.source)
	);

	logic [ROOT_W-1:0] root_expected [$];
	int errors;
	int radicands_sent;

	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// integer root seeds the guess, then Newton steps with truncating divide and halve
	function automatic logic [ROOT_W-1:0] newton_root(input logic [RAD_W-1:0] x);
		logic [63:0] whole;
		logic [63:0] trial;
		logic [63:0] guess;
		logic [63:0] scaled;
		int b;
		int k;
		if (x == '0)
			return '0;
		whole = 64'(x) >> FRAC_BITS;
		guess = '0;
		for (b = ISQ_W - 1; b >= 0; b--) begin
			trial = guess | (64'd1 << b);
			if (trial * trial <= whole)
				guess = trial;
		end
		if (guess == '0)
			guess = 64'd1;
		guess = guess << FRAC_BITS;
		scaled = 64'(x) << FRAC_BITS;
		for (k = 0; k < NEWTON_STEPS; k++) begin
			if (guess == '0)
				break;
			guess = (guess + scaled / guess) >> 1;
		end
		return guess[ROOT_W-1:0];
	endfunction

	function automatic logic [RAD_W-1:0] random_radicand();
		logic [RAD_W-1:0] r;
		int unsigned i;
		case ($urandom_range(0, 6))
			0, 1: begin
				r = $urandom;
			end
			2: begin
				r = $urandom_range(0, 32'h0000_FFFF);
			end
			3: begin
				i = $urandom_range(0, 255);
				r = (i * i) << FRAC_BITS;
				r = r + $urandom_range(0, 2) - 1;
			end
			4: begin
				r = 32'hFFFF_FFFF - $urandom_range(0, 1000);
			end
			5: begin
				r = 32'd1 << $urandom_range(0, 31);
				r = r - $urandom_range(0, 1);
			end
			default: begin
				r = ($urandom_range(1, 65535) << FRAC_BITS) | $urandom_range(0, 3);
			end
		endcase
		return r;
	endfunction

	// receiver: phases of always ready, coin flips and solid stalls, plus one long hold-off
	initial begin
		int phase_left;
		int mode;
		int hold_left;
		bit long_done;
		phase_left = 0;
		mode = 0;
		hold_left = 0;
		long_done = 1'b0;
		dout.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				dout.ready <= (hold_left == 0);
			end else if (!long_done && radicands_sent >= 40) begin
				long_done = 1'b1;
				hold_left = LONG_HOLD;
				dout.ready <= 1'b0;
			end else begin
				if (phase_left == 0) begin
					mode = $urandom_range(0, 2);
					phase_left = (mode == 2) ? $urandom_range(20, 1200)
						: $urandom_range(200, 3000);
				end
				phase_left--;
				case (mode)
					0: dout.ready <= 1'b1;
					1: dout.ready <= $urandom_range(0, 1);
					default: dout.ready <= 1'b0;
				endcase
			end
		end
	end

	// root checker
	always @(posedge clk) begin
		logic [ROOT_W-1:0] want;
		if (arst_n && dout.valid && dout.ready) begin
			if (root_expected.size() == 0) begin
				if (errors < 10)
					$display("unexpected root transfer: root=%h", dout.root);
				errors++;
			end else begin
				want = root_expected.pop_front();
				if (dout.root !== want) begin
					if (errors < 10)
						$display("root mismatch: expected %h, got %h", want, dout.root);
					errors++;
				end
			end
		end
	end

	initial begin
		#16_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		int idx;
		int burst_left;
		int gap;
		stim_row_t row;
		errors = 0;
		radicands_sent = 0;
		arst_n = 1'b0;
		din.valid <= 1'b0;
		din.radicand <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		burst_left = $urandom_range(1, 12);
		for (idx = 0; idx < N_DIR + RANDOM_ITEMS; idx++) begin
			if (idx < N_DIR)
				row = DIR_ROWS[idx];
			else
				row = '{random_radicand(), 1'b0, '0};
			din.valid <= 1'b1;
			din.radicand <= row.radicand;
			do @(posedge clk); while (!din.ready);
			root_expected.push_back(row.typed ? row.root : newton_root(row.radicand));
			radicands_sent++;
			burst_left--;
			if (burst_left == 0) begin
				case ($urandom_range(0, 19))
					0, 1, 2:        gap = $urandom_range(100, 700);
					3, 4, 5, 6, 7:  gap = $urandom_range(5, 60);
					8, 9:           gap = 0;
					default:        gap = $urandom_range(1, 4);
				endcase
				burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 40)
					: $urandom_range(1, 12);
				if (gap > 0) begin
					din.valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
		end
		din.valid <= 1'b0;
		while (root_expected.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 100) @(posedge clk);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
